>>> design/gcs_pkg.sv
// gcs_pkg: shared types, constants and the per-byte decision function of the
// comment stripper. Used by gcs_core, gcs_rsp_fifo and grammar_comment_stripper.
`default_nettype none

package gcs_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [7:0] QUOTE_RESET = 8'd34;

   // result queue depth; a transaction may push two results in one cycle
   localparam int RSP_DEPTH = 4;

   typedef enum logic [3:0] {
      CTX_PLAIN = 4'b0001,
      CTX_QUOTE = 4'b0010,
      CTX_LINE  = 4'b0100,
      CTX_BLOCK = 4'b1000
   } ctx_type;

   typedef enum logic [2:0] {
      M_NONE        = 3'd0,
      M_LINE_START  = 3'd1,
      M_LINE_END    = 3'd2,
      M_BLOCK_START = 3'd3,
      M_BLOCK_END   = 3'd4,
      M_QUOTE       = 3'd5
   } mark_type;

   typedef struct packed {
      ctx_type    ctx;
      logic [7:0] prev_byte;
      logic       prev_escape;
      logic       skip;
   } scan_type;

   typedef struct packed {
      scan_type st;
      logic     keep;
   } dec_type;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       end_of_text;
      logic       corrupted;
   } rsp_type;

   typedef struct packed {
      logic    first_vld;
      logic    second_vld;
      rsp_type first;
      rsp_type second;
   } push_type;

   localparam scan_type SCAN_RESET = '{ctx: CTX_PLAIN, prev_byte: 8'd0,
                                       prev_escape: 1'b0, skip: 1'b0};

   // decide one byte against an optional lookahead byte
   function automatic dec_type decide(input scan_type s, input logic [7:0] c,
                                      input logic [7:0] nxt, input logic has_next,
                                      input logic [7:0] quote);
      dec_type  r;
      mark_type m;
      logic     emit;
      r    = '{st: s, keep: 1'b0};
      m    = M_NONE;
      emit = 1'b0;
      if (s.skip) begin
         r.st.skip        = 1'b0;
         r.st.prev_byte   = c;
         r.st.prev_escape = 1'b0;
      end else if (c == CH_BSLASH && s.prev_byte == CH_BSLASH && !s.prev_escape) begin
         r.st.prev_byte   = c;
         r.st.prev_escape = 1'b1;
         emit = (s.ctx == CTX_PLAIN) || (s.ctx == CTX_QUOTE);
      end else begin
         if (has_next && c == CH_SLASH && nxt == CH_SLASH) m = M_LINE_START;
         else if (c == CH_LF) m = M_LINE_END;
         else if (has_next && c == CH_SLASH && nxt == CH_STAR) m = M_BLOCK_START;
         else if (has_next && c == CH_STAR && nxt == CH_SLASH) m = M_BLOCK_END;
         else if (c == quote && !(s.prev_byte == CH_BSLASH && !s.prev_escape)) m = M_QUOTE;
         case (s.ctx)
            CTX_PLAIN: begin
               if (m == M_LINE_START) begin
                  r.st.ctx  = CTX_LINE;
                  r.st.skip = 1'b1;
               end else if (m == M_BLOCK_START) begin
                  r.st.ctx  = CTX_BLOCK;
                  r.st.skip = 1'b1;
               end else begin
                  if (m == M_QUOTE) r.st.ctx = CTX_QUOTE;
                  emit = 1'b1;
               end
            end
            CTX_QUOTE: begin
               if (m == M_QUOTE) r.st.ctx = CTX_PLAIN;
               emit = 1'b1;
            end
            CTX_LINE: begin
               if (m == M_LINE_END) r.st.ctx = CTX_PLAIN;
            end
            CTX_BLOCK: begin
               if (m == M_BLOCK_END) begin
                  r.st.ctx  = CTX_PLAIN;
                  r.st.skip = 1'b1;
               end
            end
            default: begin
               r.st.ctx = CTX_PLAIN;
            end
         endcase
         r.st.prev_byte   = c;
         r.st.prev_escape = 1'b0;
      end
      // line breaks never survive
      r.keep = emit && c != CH_LF && c != CH_CR;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/gcs_core.sv
// gcs_core: scan state and the per-transaction decision of the comment stripper.
// Depends on gcs_pkg (decide function, scan and push types).
`default_nettype none

module gcs_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_last,
   input  wire logic [7:0]       quote,
   output gcs_pkg::push_type     push
);
   import gcs_pkg::*;

   scan_type   scan_ff, scan_in;
   logic [7:0] pend_ff, pend_in;
   logic       have_ff, have_in;

   dec_type    dec_p;
   dec_type    dec_l;
   scan_type   mid;
   rsp_type    r0;
   rsp_type    r1;
   logic       r0_vld;

   always_comb begin
      // pending byte decided with the new byte as lookahead
      dec_p  = decide(scan_ff, pend_ff, in_byte, 1'b1, quote);
      mid    = have_ff ? dec_p.st : scan_ff;
      r0_vld = have_ff && dec_p.keep;
      r0     = '{data: pend_ff, byte_valid: 1'b1, end_of_text: 1'b0, corrupted: 1'b0};

      // final byte of a text decided with no lookahead
      dec_l  = decide(mid, in_byte, 8'd0, 1'b0, quote);
      r1.data        = dec_l.keep ? in_byte : 8'd0;
      r1.byte_valid  = dec_l.keep;
      r1.end_of_text = 1'b1;
      r1.corrupted   = dec_l.st.ctx != CTX_PLAIN;

      push.first_vld  = step && (r0_vld || in_last);
      push.second_vld = step && r0_vld && in_last;
      push.first      = r0_vld ? r0 : r1;
      push.second     = r1;

      scan_in = scan_ff;
      pend_in = pend_ff;
      have_in = have_ff;
      if (step) begin
         if (in_last) begin
            scan_in = SCAN_RESET;
            pend_in = 8'd0;
            have_in = 1'b0;
         end else begin
            scan_in = mid;
            pend_in = in_byte;
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SCAN_RESET;
         pend_ff <= 8'd0;
         have_ff <= 1'b0;
      end else begin
         scan_ff <= scan_in;
         pend_ff <= pend_in;
         have_ff <= have_in;
      end
   end

endmodule

`default_nettype wire

>>> design/gcs_rsp_fifo.sv
// gcs_rsp_fifo: small result queue taking up to two results a cycle.
// Depends on gcs_pkg (rsp_type, push_type, RSP_DEPTH).
`default_nettype none

module gcs_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gcs_pkg::push_type push,
   output logic                   room,
   output logic                   rsp_vld,
   input  wire logic              rsp_pop,
   output gcs_pkg::rsp_type       rsp
);
   import gcs_pkg::*;

   localparam int PW = $clog2(RSP_DEPTH);
   localparam int CW = $clog2(RSP_DEPTH + 1);

   rsp_type        mem [RSP_DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           pop;
   logic [CW-1:0]  n_push;

   always_comb begin
      pop     = rsp_vld && rsp_pop;
      n_push  = CW'(push.first_vld) + CW'(push.second_vld);
      wr_in   = wr_ff + PW'(n_push);
      rd_in   = rd_ff + PW'(pop);
      cnt_in  = cnt_ff + n_push - CW'(pop);
      // a transaction may push two results
      room    = cnt_ff <= CW'(RSP_DEPTH - 2);
      rsp_vld = cnt_ff != '0;
      rsp     = mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (push.first_vld) mem[wr_ff] <= push.first;
      if (push.second_vld) mem[wr_ff + PW'(1)] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> design/grammar_comment_stripper.sv
// grammar_comment_stripper: top level; input register, csr and result queue.
// A byte's result enters the result queue in its successor's transaction.
// Throughput: one transaction per cycle while the result queue has room; a final
// byte that follows a surviving pending byte pushes two results.
// Reset clears scan state, queue and the quote register (to 34).
// Depends on gcs_pkg, gcs_core and gcs_rsp_fifo.
`default_nettype none

module grammar_comment_stripper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]       rsp_tuser,   // [0] byte_valid, [1] corrupted
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);
   import gcs_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic [7:0] quote_ff;
   logic       room;
   logic       step;
   push_type   push;
   rsp_type    rsp;

   always_comb begin
      step       = in_vld_ff && room;
      req_tready = !in_vld_ff || step;
      in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !step);
      csr_ready  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         quote_ff  <= QUOTE_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid && csr_ready) quote_ff <= csr_data;
      end
   end

   gcs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .quote   (quote_ff),
      .push    (push)
   );

   gcs_rsp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_vld (rsp_tvalid),
      .rsp_pop (rsp_tready),
      .rsp     (rsp)
   );

   assign rsp_tdata = rsp.data;
   assign rsp_tuser = {rsp.corrupted, rsp.byte_valid};
   assign rsp_tlast = rsp.end_of_text;

endmodule

`default_nettype wire
